>>> rtl/core/qme_pkg.sv
// Shared types, constants and helpers of the queue machine execute unit.
package qme_pkg;

   localparam int WORD_W      = 16;
   localparam int FUNC_W      = 5;
   localparam int REG_NUM_W   = 5;
   localparam int PC_W        = 16;
   localparam int KIND_W      = 2;
   localparam int NUM_REGS    = 26;
   localparam int REG_AW      = $clog2(NUM_REGS);
   localparam int QUEUE_DEPTH = 1024;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int STEP_W      = $clog2(WORD_W + 1);

   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH_IMM   = 5'd0,
      FN_ADD        = 5'd1,
      FN_SUB        = 5'd2,
      FN_MUL        = 5'd3,
      FN_DIV        = 5'd4,
      FN_MOD        = 5'd5,
      FN_POP_REG    = 5'd6,
      FN_PUSH_REG   = 5'd7,
      FN_PRINT_Q    = 5'd8,
      FN_PRINT_REG  = 5'd9,
      FN_CHAR_Q     = 5'd10,
      FN_CHAR_REG   = 5'd11,
      FN_LABEL      = 5'd12,
      FN_JUMP       = 5'd13,
      FN_JZ         = 5'd14,
      FN_JE         = 5'd15,
      FN_JG         = 5'd16,
      FN_QUIT       = 5'd17
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE = 2'd0,
      KIND_NUM  = 2'd1,
      KIND_CHAR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_OPB,
      ST_EXEC,
      ST_ALU,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV,
      ALU_MOD
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   // Wrap a queue index sum that is known to stay below twice the depth.
   function automatic logic [QUEUE_AW-1:0] q_wrap(input logic [QUEUE_AW:0] sum);
      logic [QUEUE_AW:0] red;
      red = sum - (QUEUE_AW+1)'(QUEUE_DEPTH);
      if (sum >= (QUEUE_AW+1)'(QUEUE_DEPTH)) begin
         return red[QUEUE_AW-1:0];
      end
      return sum[QUEUE_AW-1:0];
   endfunction

endpackage

>>> rtl/core/qme_if.sv
// Valid/ready channel interfaces for instruction items and result items.
interface qme_req_if;
   import qme_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [FUNC_W-1:0]    func;
   logic [REG_NUM_W-1:0] reg_a;
   logic [REG_NUM_W-1:0] reg_b;
   logic [WORD_W-1:0]    imm;
   logic [PC_W-1:0]      pc;
   logic [PC_W-1:0]      target;

   modport source (output valid, func, reg_a, reg_b, imm, pc, target, input ready);
   modport sink   (input valid, func, reg_a, reg_b, imm, pc, target, output ready);
endinterface

interface qme_rsp_if;
   import qme_pkg::*;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] out_kind;
   logic [WORD_W-1:0] out_value;
   logic [PC_W-1:0]   next_pc;
   logic              halted;
   logic              queue_error;

   modport source (output valid, out_kind, out_value, next_pc, halted, queue_error,
                   input ready);
   modport sink   (input valid, out_kind, out_value, next_pc, halted, queue_error,
                   output ready);
endinterface

>>> rtl/core/qme_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/qme_alu.sv
// Shared arithmetic unit: registered add/sub/mul, restoring divider one bit per cycle.
module qme_alu (
   input  logic                        clock,
   input  logic                        reset,
   input  qme_pkg::alu_req_type        alu_req,
   input  logic [qme_pkg::WORD_W-1:0]  opnd_a,
   input  logic [qme_pkg::WORD_W-1:0]  opnd_b,
   output logic                        alu_done,
   output logic [qme_pkg::WORD_W-1:0]  alu_result
);
   import qme_pkg::*;

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic                mod_ff, mod_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [WORD_W-1:0]   quo_ff, quo_in;
   logic [WORD_W-1:0]   rem_ff, rem_in;
   logic [WORD_W-1:0]   dvs_ff, dvs_in;
   logic [WORD_W-1:0]   result_ff, result_in;

   logic [WORD_W:0]     rem_sh;
   logic [WORD_W:0]     rem_sub;
   logic                ge;
   logic [WORD_W-1:0]   rem_nx;
   logic [WORD_W-1:0]   quo_nx;
   logic [2*WORD_W-1:0] product;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign rem_sh  = {rem_ff, quo_ff[WORD_W-1]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};
   assign ge      = rem_sh >= {1'b0, dvs_ff};
   assign rem_nx  = ge ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
   assign quo_nx  = {quo_ff[WORD_W-2:0], ge};
   assign product = opnd_a * opnd_b;

   always_comb begin
      run_in    = run_ff;
      done_in   = 1'b0;
      mod_in    = mod_ff;
      step_in   = step_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      result_in = result_ff;
      if (alu_req.start) begin
         case (alu_req.op)
            ALU_ADD: begin
               result_in = opnd_a + opnd_b;
               done_in   = 1'b1;
            end
            ALU_SUB: begin
               result_in = opnd_a - opnd_b;
               done_in   = 1'b1;
            end
            ALU_MUL: begin
               result_in = product[WORD_W-1:0];
               done_in   = 1'b1;
            end
            ALU_DIV, ALU_MOD: begin
               if (opnd_b == '0) begin
                  result_in = '0;
                  done_in   = 1'b1;
               end else begin
                  run_in  = 1'b1;
                  quo_in  = opnd_a;
                  rem_in  = '0;
                  dvs_in  = opnd_b;
                  step_in = STEP_W'(WORD_W);
                  mod_in  = (alu_req.op == ALU_MOD);
               end
            end
            default: begin
               result_in = '0;
               done_in   = 1'b1;
            end
         endcase
      end else if (run_ff) begin
         quo_in  = quo_nx;
         rem_in  = rem_nx;
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            run_in    = 1'b0;
            done_in   = 1'b1;
            result_in = mod_ff ? rem_nx : quo_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      mod_ff    <= mod_in;
      step_ff   <= step_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      result_ff <= result_in;
   end

   assign alu_done   = done_ff;
   assign alu_result = result_ff;
endmodule

>>> rtl/core/queue_machine_execute_unit.sv
// Top level: sequencer, queue and register file around the shared ALU.
// Rate: one item at a time. An accepted item passes ST_RD_A, ST_RD_B, ST_OPB and ST_EXEC,
//   then ST_ALU for arithmetic with two queue entries, then ST_DONE, which waits until the
//   previous result has been taken. The 16-step divider in qme_alu sets the worst case.
// Reset (synchronous, active high): queue empty, register file reads zero through
//   per-register valid bits, no result pending. Queue RAM is not cleared.
module queue_machine_execute_unit (
   input  logic     clock,
   input  logic     reset,
   qme_req_if.sink  req_ch,
   qme_rsp_if.source rsp_ch
);
   import qme_pkg::*;

   // sequencer
   state_type state_ff, state_in;

   // latched instruction item
   logic [FUNC_W-1:0]    func_ff, func_in;
   logic [REG_NUM_W-1:0] reg_a_ff, reg_a_in;
   logic [REG_NUM_W-1:0] reg_b_ff, reg_b_in;
   logic [WORD_W-1:0]    imm_ff, imm_in;
   logic [PC_W-1:0]      pc_ff, pc_in;
   logic [PC_W-1:0]      target_ff, target_in;

   // operands fetched from queue head / register file
   logic [WORD_W-1:0]    opa_ff, opa_in;
   logic [WORD_W-1:0]    opb_ff, opb_in;
   logic [WORD_W-1:0]    ra_val_ff, ra_val_in;
   logic [WORD_W-1:0]    rb_val_ff, rb_val_in;

   // queue pointers and register valid bits
   logic [QUEUE_AW-1:0]  head_ff, head_in;
   logic [QUEUE_CW-1:0]  count_ff, count_in;
   logic [NUM_REGS-1:0]  reg_valid_ff, reg_valid_in;

   // result item register
   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             kind_ff, kind_in;
   logic [WORD_W-1:0]    value_ff, value_in;
   logic [PC_W-1:0]      next_pc_ff, next_pc_in;
   logic                 halted_ff, halted_in;
   logic                 err_ff, err_in;

   // memories
   logic                 q_we;
   logic [QUEUE_AW-1:0]  q_wr_addr, q_rd_addr;
   logic [WORD_W-1:0]    q_wr_data, q_rd_data;
   logic                 r_we;
   logic [REG_AW-1:0]    r_wr_addr, r_rd_addr;
   logic [WORD_W-1:0]    r_wr_data, r_rd_data;

   // ALU
   alu_req_type          alu_req;
   logic                 alu_done;
   logic [WORD_W-1:0]    alu_result;

   logic                 req_acc;
   logic                 done_go;
   logic                 is_arith;
   logic                 q_full;
   logic                 q_empty;
   logic [QUEUE_AW-1:0]  tail;
   logic [REG_NUM_W-1:0] reg_sel;
   logic [WORD_W-1:0]    r_val;
   logic                 jump;
   kind_type             kind_nx;
   logic [WORD_W-1:0]    value_nx;
   logic [PC_W-1:0]      base_pc;

   qme_ram #(.WIDTH(WORD_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_wr_addr),
      .wr_data (q_wr_data),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

   qme_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_reg_ram (
      .clock   (clock),
      .wr_en   (r_we),
      .wr_addr (r_wr_addr),
      .wr_data (r_wr_data),
      .rd_addr (r_rd_addr),
      .rd_data (r_rd_data)
   );

   qme_alu u_alu (
      .clock      (clock),
      .reset      (reset),
      .alu_req    (alu_req),
      .opnd_a     (opa_ff),
      .opnd_b     (opb_ff),
      .alu_done   (alu_done),
      .alu_result (alu_result)
   );

   assign req_acc  = req_ch.valid && req_ch.ready;
   // the result register may be reloaded once the previous result has left
   assign done_go  = (state_ff == ST_DONE) && !(rsp_valid_ff && !rsp_ch.ready);
   assign is_arith = (func_ff == FN_ADD) || (func_ff == FN_SUB) || (func_ff == FN_MUL) ||
                     (func_ff == FN_DIV) || (func_ff == FN_MOD);
   assign q_full   = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign q_empty  = (count_ff == '0);
   // slot after the newest entry
   assign tail     = q_wrap((QUEUE_AW+1)'(head_ff) + (QUEUE_AW+1)'(count_ff));

   // register read: out-of-range numbers and never-written registers read zero.
   // reg_a data lands in ST_RD_B, reg_b data in ST_OPB.
   assign reg_sel = (state_ff == ST_RD_B) ? reg_a_ff : reg_b_ff;
   always_comb begin
      r_val = '0;
      if (reg_sel < REG_NUM_W'(NUM_REGS)) begin
         if (reg_valid_ff[REG_AW'(reg_sel)]) begin
            r_val = r_rd_data;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_RD_A;
            end
         end
         ST_RD_A: state_in = ST_RD_B;
         ST_RD_B: state_in = ST_OPB;
         ST_OPB:  state_in = ST_EXEC;
         ST_EXEC: begin
            if (is_arith && (count_ff >= QUEUE_CW'(2))) begin
               state_in = ST_ALU;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ALU: begin
            if (alu_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake, read addresses, ALU start
   always_comb begin
      req_ch.ready  = 1'b0;
      q_rd_addr     = head_ff;
      r_rd_addr     = REG_AW'(reg_a_ff);
      alu_req.start = 1'b0;
      case (func_ff)
         FN_SUB:  alu_req.op = ALU_SUB;
         FN_MUL:  alu_req.op = ALU_MUL;
         FN_DIV:  alu_req.op = ALU_DIV;
         FN_MOD:  alu_req.op = ALU_MOD;
         default: alu_req.op = ALU_ADD;
      endcase
      case (state_ff)
         ST_IDLE: req_ch.ready = 1'b1;
         ST_RD_A: begin
            q_rd_addr = head_ff;
            r_rd_addr = REG_AW'(reg_a_ff);
         end
         ST_RD_B: begin
            // second queue entry, one past the head
            q_rd_addr = q_wrap((QUEUE_AW+1)'(head_ff) + (QUEUE_AW+1)'(1));
            r_rd_addr = REG_AW'(reg_b_ff);
         end
         ST_EXEC: alu_req.start = is_arith && (count_ff >= QUEUE_CW'(2));
         default: ;
      endcase
   end

   // datapath: operand capture, execution and write-back
   always_comb begin
      func_in      = func_ff;
      reg_a_in     = reg_a_ff;
      reg_b_in     = reg_b_ff;
      imm_in       = imm_ff;
      pc_in        = pc_ff;
      target_in    = target_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      ra_val_in    = ra_val_ff;
      rb_val_in    = rb_val_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      reg_valid_in = reg_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      kind_in      = kind_ff;
      value_in     = value_ff;
      next_pc_in   = next_pc_ff;
      halted_in    = halted_ff;
      err_in       = err_ff;
      q_we         = 1'b0;
      q_wr_addr    = tail;
      q_wr_data    = imm_ff;
      r_we         = 1'b0;
      r_wr_addr    = REG_AW'(reg_a_ff);
      r_wr_data    = opa_ff;
      jump         = 1'b0;
      kind_nx      = KIND_NONE;
      value_nx     = '0;
      base_pc      = pc_ff;

      if (req_acc) begin
         func_in   = req_ch.func;
         reg_a_in  = req_ch.reg_a;
         reg_b_in  = req_ch.reg_b;
         imm_in    = req_ch.imm;
         pc_in     = req_ch.pc;
         target_in = req_ch.target;
      end

      case (state_ff)
         ST_RD_B: begin
            opa_in    = q_rd_data;
            ra_val_in = r_val;
         end
         ST_OPB: begin
            opb_in    = q_rd_data;
            rb_val_in = r_val;
         end
         ST_DONE: begin
            if (done_go) begin
               err_in    = 1'b0;
               halted_in = 1'b0;
               case (func_ff)
                  FN_PUSH_IMM: begin
                     if (q_full) begin
                        err_in = 1'b1;
                     end else begin
                        q_we      = 1'b1;
                        q_wr_data = imm_ff;
                        count_in  = count_ff + QUEUE_CW'(1);
                     end
                  end
                  FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD: begin
                     if (count_ff < QUEUE_CW'(2)) begin
                        err_in = 1'b1;
                     end else begin
                        // two popped, one pushed: the result goes to the slot after the newest entry
                        q_we      = 1'b1;
                        q_wr_data = alu_result;
                        head_in   = q_wrap((QUEUE_AW+1)'(head_ff) + (QUEUE_AW+1)'(2));
                        count_in  = count_ff - QUEUE_CW'(1);
                     end
                  end
                  FN_POP_REG: begin
                     if (q_empty) begin
                        err_in = 1'b1;
                     end else begin
                        if (reg_a_ff < REG_NUM_W'(NUM_REGS)) begin
                           r_we = 1'b1;
                           reg_valid_in[REG_AW'(reg_a_ff)] = 1'b1;
                        end
                        head_in  = q_wrap((QUEUE_AW+1)'(head_ff) + (QUEUE_AW+1)'(1));
                        count_in = count_ff - QUEUE_CW'(1);
                     end
                  end
                  FN_PUSH_REG: begin
                     if (q_full) begin
                        err_in = 1'b1;
                     end else begin
                        q_we      = 1'b1;
                        q_wr_data = ra_val_ff;
                        count_in  = count_ff + QUEUE_CW'(1);
                     end
                  end
                  FN_PRINT_Q, FN_CHAR_Q: begin
                     if (q_empty) begin
                        err_in = 1'b1;
                     end else begin
                        value_nx = opa_ff;
                        kind_nx  = (func_ff == FN_PRINT_Q) ? KIND_NUM : KIND_CHAR;
                        head_in  = q_wrap((QUEUE_AW+1)'(head_ff) + (QUEUE_AW+1)'(1));
                        count_in = count_ff - QUEUE_CW'(1);
                     end
                  end
                  FN_PRINT_REG, FN_CHAR_REG: begin
                     value_nx = ra_val_ff;
                     kind_nx  = (func_ff == FN_PRINT_REG) ? KIND_NUM : KIND_CHAR;
                  end
                  FN_JUMP: jump = 1'b1;
                  FN_JZ:   jump = (ra_val_ff == '0);
                  FN_JE:   jump = (ra_val_ff == rb_val_ff);
                  FN_JG:   jump = (ra_val_ff > rb_val_ff);
                  FN_QUIT: halted_in = 1'b1;
                  default: ;
               endcase
               // characters print modulo 256
               if (kind_nx == KIND_CHAR) begin
                  value_nx = {{(WORD_W-8){1'b0}}, value_nx[7:0]};
               end
               base_pc      = jump ? target_ff : pc_ff;
               next_pc_in   = base_pc + PC_W'(1);
               kind_in      = kind_nx;
               value_in     = value_nx;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         reg_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         reg_valid_ff <= reg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff    <= func_in;
      reg_a_ff   <= reg_a_in;
      reg_b_ff   <= reg_b_in;
      imm_ff     <= imm_in;
      pc_ff      <= pc_in;
      target_ff  <= target_in;
      opa_ff     <= opa_in;
      opb_ff     <= opb_in;
      ra_val_ff  <= ra_val_in;
      rb_val_ff  <= rb_val_in;
      kind_ff    <= kind_in;
      value_ff   <= value_in;
      next_pc_ff <= next_pc_in;
      halted_ff  <= halted_in;
      err_ff     <= err_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_kind    = kind_ff;
   assign rsp_ch.out_value   = value_ff;
   assign rsp_ch.next_pc     = next_pc_ff;
   assign rsp_ch.halted      = halted_ff;
   assign rsp_ch.queue_error = err_ff;

   // queue occupancy never runs past the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CW'(QUEUE_DEPTH))
      else $error("queue count exceeds depth");

   // the ALU only reports while the sequencer waits for it
   a_alu_done_state: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> (state_ff == ST_ALU))
      else $error("ALU done outside wait state");

   // register writes only reach existing registers, and only at write-back
   a_reg_write: assert property (@(posedge clock) disable iff (reset)
      r_we |-> ((reg_a_ff < REG_NUM_W'(NUM_REGS)) && (state_ff == ST_DONE)))
      else $error("bad register file write");

   // a new result is loaded only once the pending one has been taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> (rsp_valid_ff && $stable(value_ff)))
      else $error("pending result overwritten");
endmodule
